[hdl/chm_pkg.sv]
package chm_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_BUCKETS = 1024;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int BADDR_W     = $clog2(MAX_BUCKETS);
    localparam int LINK_W      = ADDR_W + 1;
    localparam int CNT_W       = 11;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int DVD_W       = 64;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STEPS   = DVD_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0]  CFG_RESET = CNT_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_WALK,
        S_CMP,
        S_FREE,
        S_G_HEAD,
        S_G_HWAIT,
        S_G_CHAIN,
        S_G_LWAIT,
        S_G_CLR,
        S_G_DIST,
        S_G_DKEY,
        S_G_DMOD,
        S_G_DHEAD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [CNT_W-1:0]  remainder;
    } mod_rsp_t;

    function automatic logic [CNT_W-1:0] clamp_buckets(input logic [CNT_W:0] b);
        logic [CNT_W-1:0] r;
        if (b == '0)
            r = CNT_W'(1);
        else if (b > (CNT_W+1)'(MAX_BUCKETS))
            r = CNT_W'(MAX_BUCKETS);
        else
            r = b[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [DVD_W-1:0] sext_key(input logic [KEY_BITS-1:0] k);
        return {{(DVD_W-KEY_BITS){k[KEY_BITS-1]}}, k};
    endfunction

endpackage

[hdl/chm_if.sv]
interface chm_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [chm_pkg::CMD_W-1:0]               command;
    logic signed [chm_pkg::KEY_BITS-1:0]     key;
    logic signed [chm_pkg::VALUE_BITS-1:0]   write_value;
    modport source (output valid, command, key, write_value, input ready);
    modport sink   (input valid, command, key, write_value, output ready);
endinterface

interface chm_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [chm_pkg::STATUS_W-1:0]            status;
    logic signed [chm_pkg::VALUE_BITS-1:0]   read_value;
    logic [chm_pkg::CNT_W-1:0]               entry_count;
    logic [chm_pkg::CNT_W-1:0]               bucket_count;
    modport source (output valid, status, read_value, entry_count, bucket_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, bucket_count, output ready);
endinterface

interface chm_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [chm_pkg::CNT_W-1:0]               data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/chm_mod_unit.sv]
module chm_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  chm_pkg::mod_req_t  req,
    output chm_pkg::mod_rsp_t  rsp
);
    import chm_pkg::*;

    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W:0]       part;

    // two restoring steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        part     = '0;
        for (int s = 0; s < DIV_BITS; s++)
        begin
            part = {rem_next, dvd_next[DVD_W-1]};
            if (part >= {1'b0, div_reg})
                part = part - {1'b0, div_reg};
            rem_next = part[CNT_W-1:0];
            dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

[hdl/chained_hash_map_engine_core.sv]
// Key/value map with separate chaining over 32-bit signed keys. Each input word is a write,
// read or remove (other codes change nothing and get status OK) and yields one result word
// with status, read value, entry count and bucket count. After reset the block clears its
// bucket heads and free list and accepts no word meanwhile; configuration writes are taken
// at any time. Each operation finds its bucket with a serial modulo (64-bit dividend, two
// bits per cycle), walks the chain entry by entry, then does the update and the result. A
// write that triggers growth adds a rehash that gathers the old chains into one list, then
// redistributes each entry, bound by the modulo unit and each memory's single read port.
module chained_hash_map_engine_core (
    input  logic  clk,
    input  logic  rst_n,
    chm_in_if.sink    in_ch,
    chm_out_if.source out_ch,
    chm_cfg_if.sink   cfg_ch
);
    import chm_pkg::*;

    logic [LINK_W-1:0]     heads_mem [MAX_BUCKETS];
    logic [KEY_BITS-1:0]   keys_mem  [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] vals_mem  [MAX_ENTRIES];
    logic [LINK_W-1:0]     links_mem [MAX_ENTRIES];
    logic [ADDR_W-1:0]     free_mem  [MAX_ENTRIES];

    logic [LINK_W-1:0]     head_rd, link_rd;
    logic [KEY_BITS-1:0]   key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic [ADDR_W-1:0]     free_rd;

    logic                  head_we, link_we, key_we, val_we, free_we;
    logic [BADDR_W-1:0]    head_waddr, head_raddr;
    logic [LINK_W-1:0]     head_wdata, link_wdata;
    logic [ADDR_W-1:0]     link_waddr, val_waddr, free_waddr, free_wdata, ent_raddr, free_raddr;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] wval_reg, wval_next;
    logic [BADDR_W-1:0]    bkt_reg, bkt_next;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [LINK_W-1:0]     node_reg, node_next;
    logic [LINK_W-1:0]     prev_reg, prev_next;
    logic [LINK_W-1:0]     glist_reg, glist_next;
    logic [LINK_W-1:0]     nxt_reg, nxt_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      old_reg, old_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      live_reg, live_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [VALUE_BITS-1:0] rv_reg, rv_next;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [VALUE_BITS-1:0] out_rv_reg;
    logic [CNT_W-1:0]      out_count_reg, out_live_reg;

    mod_req_t              mreq;
    mod_rsp_t              mrsp;

    logic                  in_fire, out_free, key_hit, at_end, grow_now;
    logic [CNT_W-1:0]      idx_inc, thr, dbl, count_inc, free_put;

    chm_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign key_hit      = (key_rd == key_reg);
    assign idx_inc      = idx_reg + CNT_W'(1);
    assign at_end       = (idx_inc == old_reg);
    assign thr          = (live_reg >> 1) + (live_reg >> 2) - (live_reg >> 3);
    assign dbl          = clamp_buckets({live_reg, 1'b0});
    assign count_inc    = count_reg + CNT_W'(1);
    assign grow_now     = (count_inc > thr) && (dbl != live_reg);
    assign free_put     = CNT_W'(MAX_ENTRIES) - count_reg;

    assign cfg_ch.ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP:
                if (idx_reg == CNT_W'(MAX_ENTRIES - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (in_fire)
                begin
                    if (in_ch.command inside {CMD_WRITE, CMD_READ, CMD_REMOVE})
                        state_next = S_HASH;
                    else
                        state_next = S_DONE;
                end
            S_HASH:
                if (mrsp.done)
                    state_next = S_HEAD;
            S_HEAD:
                state_next = S_WALK;
            S_WALK:
                if (node_reg != NIL_LINK)
                    state_next = S_CMP;
                else if (cmd_reg == CMD_WRITE && count_reg < CNT_W'(MAX_ENTRIES))
                    state_next = S_FREE;
                else
                    state_next = S_DONE;
            S_CMP:
                state_next = key_hit ? S_DONE : S_WALK;
            S_FREE:
                state_next = grow_now ? S_G_HEAD : S_DONE;
            S_G_HEAD:
                state_next = S_G_HWAIT;
            S_G_HWAIT:
                state_next = S_G_CHAIN;
            S_G_CHAIN:
                if (node_reg != NIL_LINK)
                    state_next = S_G_LWAIT;
                else if (at_end)
                    state_next = S_G_CLR;
                else
                    state_next = S_G_HEAD;
            S_G_LWAIT:
                state_next = S_G_CHAIN;
            S_G_CLR:
                if (at_end)
                    state_next = S_G_DIST;
            S_G_DIST:
                state_next = (node_reg == NIL_LINK) ? S_DONE : S_G_DKEY;
            S_G_DKEY:
                state_next = S_G_DMOD;
            S_G_DMOD:
                if (mrsp.done)
                    state_next = S_G_DHEAD;
            S_G_DHEAD:
                state_next = S_G_DIST;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // memory control and modulo requests
    always_comb
    begin
        head_we       = 1'b0;
        head_waddr    = bkt_reg;
        head_wdata    = NIL_LINK;
        link_we       = 1'b0;
        link_waddr    = node_reg[ADDR_W-1:0];
        link_wdata    = NIL_LINK;
        key_we        = 1'b0;
        val_we        = 1'b0;
        val_waddr     = node_reg[ADDR_W-1:0];
        free_we       = 1'b0;
        free_waddr    = idx_reg[ADDR_W-1:0];
        free_wdata    = idx_reg[ADDR_W-1:0];
        head_raddr    = idx_reg[BADDR_W-1:0];
        ent_raddr     = node_reg[ADDR_W-1:0];
        free_raddr    = ADDR_W'(CNT_W'(MAX_ENTRIES - 1) - count_reg);
        mreq.start    = 1'b0;
        mreq.dividend = sext_key(in_ch.key);
        mreq.divisor  = live_reg;
        case (state_reg)
            S_SWEEP:
            begin
                head_we    = 1'b1;
                head_waddr = idx_reg[BADDR_W-1:0];
                free_we    = 1'b1;
            end
            S_IDLE:
                mreq.start = in_fire;
            S_HASH:
                head_raddr = mrsp.remainder[BADDR_W-1:0];
            S_CMP:
                if (key_hit)
                begin
                    if (cmd_reg == CMD_WRITE)
                        val_we = 1'b1;
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        if (prev_reg == NIL_LINK)
                        begin
                            head_we    = 1'b1;
                            head_wdata = link_rd;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg[ADDR_W-1:0];
                            link_wdata = link_rd;
                        end
                        free_we    = 1'b1;
                        free_waddr = free_put[ADDR_W-1:0];
                        free_wdata = node_reg[ADDR_W-1:0];
                    end
                end
            S_FREE:
            begin
                key_we     = 1'b1;
                val_we     = 1'b1;
                val_waddr  = free_rd;
                link_we    = 1'b1;
                link_waddr = free_rd;
                link_wdata = head_reg;
                head_we    = 1'b1;
                head_wdata = {1'b0, free_rd};
            end
            S_G_LWAIT:
            begin
                link_we    = 1'b1;
                link_wdata = glist_reg;
            end
            S_G_CLR:
            begin
                head_we    = 1'b1;
                head_waddr = idx_reg[BADDR_W-1:0];
            end
            S_G_DKEY:
            begin
                mreq.start    = 1'b1;
                mreq.dividend = sext_key(key_rd);
            end
            S_G_DMOD:
                head_raddr = mrsp.remainder[BADDR_W-1:0];
            S_G_DHEAD:
            begin
                link_we    = 1'b1;
                link_wdata = head_rd;
                head_we    = 1'b1;
                head_wdata = node_reg;
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        wval_next   = wval_reg;
        bkt_next    = bkt_reg;
        head_next   = head_reg;
        node_next   = node_reg;
        prev_next   = prev_reg;
        glist_next  = glist_reg;
        nxt_next    = nxt_reg;
        idx_next    = idx_reg;
        old_next    = old_reg;
        count_next  = count_reg;
        live_next   = live_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        case (state_reg)
            S_SWEEP:
                idx_next = idx_inc;
            S_IDLE:
                if (in_fire)
                begin
                    cmd_next    = in_ch.command;
                    key_next    = in_ch.key;
                    wval_next   = in_ch.write_value;
                    status_next = ST_OK;
                    rv_next     = '0;
                end
            S_HASH:
                bkt_next = mrsp.remainder[BADDR_W-1:0];
            S_HEAD:
            begin
                head_next = head_rd;
                node_next = head_rd;
                prev_next = NIL_LINK;
            end
            S_WALK:
                if (node_reg == NIL_LINK)
                begin
                    if (cmd_reg != CMD_WRITE)
                        status_next = ST_NOT_FOUND;
                    else if (count_reg >= CNT_W'(MAX_ENTRIES))
                        status_next = ST_FULL;
                end
            S_CMP:
                if (key_hit)
                begin
                    if (cmd_reg == CMD_READ)
                        rv_next = val_rd;
                    else if (cmd_reg == CMD_REMOVE)
                        count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    prev_next = node_reg;
                    node_next = link_rd;
                end
            S_FREE:
            begin
                count_next = count_inc;
                if (grow_now)
                begin
                    old_next   = live_reg;
                    live_next  = dbl;
                    idx_next   = '0;
                    glist_next = NIL_LINK;
                end
            end
            S_G_HWAIT:
                node_next = head_rd;
            S_G_CHAIN:
                if (node_reg == NIL_LINK)
                    idx_next = at_end ? '0 : idx_inc;
            S_G_LWAIT:
            begin
                glist_next = node_reg;
                node_next  = link_rd;
            end
            S_G_CLR:
            begin
                idx_next = idx_inc;
                if (at_end)
                    node_next = glist_reg;
            end
            S_G_DKEY:
                nxt_next = link_rd;
            S_G_DMOD:
                bkt_next = mrsp.remainder[BADDR_W-1:0];
            S_G_DHEAD:
                node_next = nxt_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            idx_reg       <= '0;
            count_reg     <= '0;
            live_reg      <= clamp_buckets({1'b0, CFG_RESET});
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cfg_ch.valid)
            begin
                if (count_reg == '0)
                    live_reg <= clamp_buckets({1'b0, cfg_ch.data});
            end
            else
                live_reg <= live_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        wval_reg   <= wval_next;
        bkt_reg    <= bkt_next;
        head_reg   <= head_next;
        node_reg   <= node_next;
        prev_reg   <= prev_next;
        glist_reg  <= glist_next;
        nxt_reg    <= nxt_next;
        old_reg    <= old_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= status_reg;
            out_rv_reg     <= rv_reg;
            out_count_reg  <= count_reg;
            out_live_reg   <= live_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            heads_mem[head_waddr] <= head_wdata;
        head_rd <= heads_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            keys_mem[free_rd] <= key_reg;
        key_rd <= keys_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            vals_mem[val_waddr] <= wval_reg;
        val_rd <= vals_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            links_mem[link_waddr] <= link_wdata;
        link_rd <= links_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_waddr] <= free_wdata;
        free_rd <= free_mem[free_raddr];
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.read_value   = out_rv_reg;
    assign out_ch.entry_count  = out_count_reg;
    assign out_ch.bucket_count = out_live_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above pool size");

    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg != '0 && live_reg <= CNT_W'(MAX_BUCKETS))
        else $error("bucket count out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) == S_CMP || $past(state_reg) == S_FREE)
        else $error("entry count changed outside an update");

    a_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        $past(count_reg) != '0 && count_reg != '0 |-> live_reg >= $past(live_reg))
        else $error("bucket count shrank while entries held");

endmodule

[tb/chained_hash_map_engine_core_tb.sv]
`timescale 1ns / 1ps

module chained_hash_map_engine_core_tb;
    import chm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [CMD_W-1:0]             command;
        logic signed [KEY_BITS-1:0]   key;
        logic signed [VALUE_BITS-1:0] write_value;
    } map_op_t;

    typedef struct {
        status_t                      status;
        logic signed [VALUE_BITS-1:0] read_value;
        logic [CNT_W-1:0]             entry_count;
        logic [CNT_W-1:0]             bucket_count;
    } map_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    chm_in_if  in_ch();
    chm_out_if out_ch();
    chm_cfg_if cfg_ch();

    chained_hash_map_engine_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #5 clk = ~clk;

    map_op_t    op_queue[$];
    map_reply_t reply_queue[$];
    logic signed [VALUE_BITS-1:0] stored_values[int];
    logic [CNT_W-1:0] live_buckets = CFG_RESET;
    int key_pool[48];
    int errors = 0;
    int cycles = 0;
    int hold_cycles = 0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int send_gap = 0;
    int recv_stall = 0;
    bit quiet = 1'b0;

    function automatic logic [CNT_W-1:0] next_buckets(input logic [CNT_W-1:0] b);
        logic [CNT_W:0] d;
        d = {b, 1'b0};
        if (d > MAX_BUCKETS)
            return CNT_W'(MAX_BUCKETS);
        return d[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] taken_buckets(input logic [CNT_W-1:0] v);
        if (v == 0)
            return CNT_W'(1);
        if (v > MAX_BUCKETS)
            return CNT_W'(MAX_BUCKETS);
        return v;
    endfunction

    function automatic map_reply_t apply_map_op(input map_op_t op);
        map_reply_t r;
        int k;
        int thr;
        k = op.key;
        r.status = ST_OK;
        r.read_value = '0;
        case (op.command)
            CMD_WRITE:
            begin
                if (stored_values.exists(k))
                    stored_values[k] = op.write_value;
                else if (stored_values.num() >= MAX_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    stored_values[k] = op.write_value;
                    thr = (live_buckets >> 1) + (live_buckets >> 2) - (live_buckets >> 3);
                    if (stored_values.num() > thr)
                        live_buckets = next_buckets(live_buckets);
                end
            end
            CMD_READ:
            begin
                if (stored_values.exists(k))
                    r.read_value = stored_values[k];
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_REMOVE:
            begin
                if (stored_values.exists(k))
                    stored_values.delete(k);
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        r.entry_count = CNT_W'(stored_values.num());
        r.bucket_count = live_buckets;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.command <= '0;
            in_ch.key <= '0;
            in_ch.write_value <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                reply_queue.push_back(apply_map_op(op_queue[0]));
                op_queue.pop_front();
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 12) - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.command <= op_queue[0].command;
                    in_ch.key <= op_queue[0].key;
                    in_ch.write_value <= op_queue[0].write_value;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_cycles <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        map_reply_t e;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (reply_queue.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = reply_queue.pop_front();
                    if (out_ch.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_ch.status);
                        errors++;
                    end
                    if (out_ch.read_value !== e.read_value)
                    begin
                        $error("read_value exp %0d got %0d", e.read_value, out_ch.read_value);
                        errors++;
                    end
                    if (out_ch.entry_count !== e.entry_count)
                    begin
                        $error("entry_count exp %0d got %0d", e.entry_count, out_ch.entry_count);
                        errors++;
                    end
                    if (out_ch.bucket_count !== e.bucket_count)
                    begin
                        $error("bucket_count exp %0d got %0d", e.bucket_count,
                               out_ch.bucket_count);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
                out_ch.ready <= 1'b0;
            else if (quiet)
                out_ch.ready <= 1'b1;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                recv_stall = $urandom_range(1, 12) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_op(input logic [CMD_W-1:0] c, input int k, input int v);
        map_op_t op;
        op.command = c;
        op.key = k;
        op.write_value = v;
        op_queue.push_back(op);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (op_queue.size() > 0 || in_ch.valid || reply_queue.size() > 0);
    endtask

    task automatic write_buckets(input logic [CNT_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        if (stored_values.num() == 0)
            live_buckets = taken_buckets(v);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic remove_all();
        int keys[$];
        foreach (stored_values[k])
            keys.push_back(k);
        foreach (keys[i])
            push_op(CMD_REMOVE, keys[i], 0);
        wait_idle();
    endtask

    task automatic random_ops(input int n);
        int k;
        int r;
        logic [CMD_W-1:0] c;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                c = CMD_WRITE;
            else if (r < 70)
                c = CMD_READ;
            else if (r < 95)
                c = CMD_REMOVE;
            else
                c = CMD_UNUSED;
            if ($urandom_range(0, 4) != 0)
                k = key_pool[$urandom_range(0, 47)];
            else
                k = $urandom;
            push_op(c, k, $urandom);
        end
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero taken as one bucket
        write_buckets(CNT_W'(0));
        push_op(CMD_WRITE, 32'h8000_0000, 32'h7fff_ffff);
        push_op(CMD_WRITE, 32'h7fff_ffff, 32'h8000_0000);
        push_op(CMD_WRITE, 0, -1);
        push_op(CMD_WRITE, -1, 0);
        push_op(CMD_READ, 32'h8000_0000, 0);
        push_op(CMD_READ, 32'h7fff_ffff, 0);
        push_op(CMD_READ, 0, 0);
        push_op(CMD_READ, -1, 0);
        push_op(CMD_READ, 12345, 0);
        push_op(CMD_WRITE, 0, 32'h5a5a_a5a5);
        push_op(CMD_READ, 0, 0);
        push_op(CMD_REMOVE, -1, 0);
        push_op(CMD_REMOVE, -1, 0);
        push_op(CMD_READ, -1, 0);
        push_op(CMD_UNUSED, 0, 32'h1234_5678);
        push_op(CMD_UNUSED, 777, 0);
        push_op(CMD_WRITE, 1, 0);
        push_op(CMD_WRITE, 2, 0);
        push_op(CMD_REMOVE, 32'h8000_0000, 0);
        random_ops(100);
        wait_idle();

        // register above the maximum saturates
        remove_all();
        write_buckets(CNT_W'(2047));
        random_ops(100);
        wait_idle();

        // register written while entries are held keeps the bucket count
        write_buckets(CNT_W'(1));
        hold_request = 1'b1;
        random_ops(100);
        wait_idle();

        remove_all();
        write_buckets(CNT_W'(MAX_BUCKETS));
        random_ops(60);
        wait_idle();

        // grow through several doublings
        remove_all();
        write_buckets(CNT_W'(3));
        for (int i = 0; i < 120; i++)
            push_op(CMD_WRITE, i * 7919 - 4000000, i);
        push_op(CMD_WRITE, 99999999, 5);
        push_op(CMD_WRITE, -4000000, 42);
        push_op(CMD_READ, -4000000, 0);
        push_op(CMD_READ, 99999999, 0);
        wait_idle();

        write_buckets(CNT_W'($urandom_range(1, 1024)));
        write_buckets(CFG_RESET);
        random_ops(40);
        wait_idle();
        quiet = 1'b1;
        random_ops(60);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/chm_pkg.sv
hdl/chm_if.sv
hdl/chm_mod_unit.sv
hdl/chained_hash_map_engine_core.sv
tb/chained_hash_map_engine_core_tb.sv
